// File: rtl/ethiopian_to_gregorian_date_macros.svh
// Assertion macros used by the checker file of the date converter.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ETHIOPIAN_TO_GREGORIAN_DATE_MACROS_SVH
`define ETHIOPIAN_TO_GREGORIAN_DATE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define E2G_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("date converter assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define E2G_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("date converter assertion failed");

`endif

// File: rtl/e2g_pkg.sv
`default_nettype none

package e2g_pkg;

    // Field widths of the two items.
    localparam int DayW   = 5;
    localparam int MonthW = 4;
    localparam int YearW  = 14;

    // Named Ethiopian months that the conversion treats specially.
    localparam logic [MonthW-1:0] MONTH_YEKATIT = 4'd5;
    localparam logic [MonthW-1:0] MONTH_PAGUME  = 4'd12;

    // Gregorian year addend that applies to Yekatit.
    localparam logic [3:0] YEKATIT_YADD = 4'd8;

    // Reciprocal of 25 scaled by 2^20, exact for any 15-bit dividend.
    localparam int          RecipShift = 20;
    localparam logic [15:0] RECIP_25   = 16'd41944;

    typedef struct packed {
        logic [DayW-1:0]   eth_day;
        logic [MonthW-1:0] eth_month;
        logic [YearW-1:0]  eth_year;
    } eth_date_t;

    typedef struct packed {
        logic [DayW-1:0]   greg_day;
        logic [MonthW-1:0] greg_month;
        logic [YearW-1:0]  greg_year;
        logic              valid_res;
    } greg_date_t;

    // Per-month tables; entries above Pagume are never used.
    localparam logic [DayW-1:0] SPLIT_BASE [16] = '{
        5'd20, 5'd21, 5'd21, 5'd22, 5'd23, 5'd21, 5'd22, 5'd22,
        5'd23, 5'd23, 5'd24, 5'd25, 5'd31, 5'd0, 5'd0, 5'd0
    };
    localparam logic [DayW-1:0] LOW_OFFSET [16] = '{
        5'd10, 5'd10, 5'd9, 5'd9, 5'd8, 5'd7, 5'd9, 5'd8,
        5'd8, 5'd7, 5'd7, 5'd6, 5'd5, 5'd0, 5'd0, 5'd0
    };
    localparam logic [MonthW-1:0] LOW_GMONTH [16] = '{
        4'd9, 4'd10, 4'd11, 4'd12, 4'd1, 4'd2, 4'd3, 4'd4,
        4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd0, 4'd0, 4'd0
    };
    localparam logic [MonthW-1:0] HIGH_GMONTH [16] = '{
        4'd10, 4'd11, 4'd12, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5,
        4'd6, 4'd7, 4'd8, 4'd9, 4'd9, 4'd0, 4'd0, 4'd0
    };
    localparam logic [3:0] LOW_YADD [16] = '{
        4'd7, 4'd7, 4'd7, 4'd7, 4'd8, 4'd8, 4'd8, 4'd8,
        4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd0, 4'd0, 4'd0
    };
    localparam logic [3:0] HIGH_YADD [16] = '{
        4'd7, 4'd7, 4'd7, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8,
        4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd0, 4'd0, 4'd0
    };

endpackage

`default_nettype wire

// File: rtl/e2g_convert.sv
`default_nettype none

module e2g_convert (
    input  wire e2g_pkg::eth_date_t  eth,
    output e2g_pkg::greg_date_t      greg
);
    import e2g_pkg::*;

    logic                 leap;
    logic [14:0]          gy;
    logic [30:0]          prod;
    logic [9:0]           quot;
    logic [14:0]          rem25;
    logic                 greg_leap;
    logic [DayW-1:0]      split;
    logic                 low_side;
    logic [YearW-1:0]     year_low;
    logic [YearW-1:0]     year_high;

    always_comb
    begin
        // The previous Ethiopian year was a leap year when this year is a multiple of four.
        leap = (eth.eth_month <= MONTH_YEKATIT) && (eth.eth_year[1:0] == 2'b00);

        // Gregorian leap test on the year that Yekatit falls in; divisibility by 25
        // comes from a reciprocal multiply, and by 100 or 400 follows with 4 or 16.
        gy        = {1'b0, eth.eth_year} + 15'(YEKATIT_YADD);
        prod      = 31'(gy) * 31'(RECIP_25);
        quot      = prod[RecipShift+9:RecipShift];
        rem25     = gy - 15'({quot, 4'b0000}) - 15'({quot, 3'b000}) - 15'(quot);
        greg_leap = (gy[1:0] == 2'b00) && ((rem25 != 15'd0) || (gy[3:0] == 4'b0000));

        // Split day of the month after both leap corrections.
        split = SPLIT_BASE[eth.eth_month] - 5'(leap)
              + 5'((eth.eth_month == MONTH_YEKATIT) && greg_leap);
        low_side = (eth.eth_day <= split);

        year_low  = eth.eth_year + 14'(LOW_YADD[eth.eth_month]);
        year_high = eth.eth_year + 14'(HIGH_YADD[eth.eth_month]);

        // Select the side of the split; months beyond Pagume give an all-zero result.
        greg = '0;
        if (eth.eth_month <= MONTH_PAGUME)
        begin
            greg.valid_res = 1'b1;
            if (low_side)
            begin
                greg.greg_day   = eth.eth_day + LOW_OFFSET[eth.eth_month] + 5'(leap);
                greg.greg_month = LOW_GMONTH[eth.eth_month];
                greg.greg_year  = year_low;
            end
            else
            begin
                greg.greg_day   = eth.eth_day - split;
                greg.greg_month = HIGH_GMONTH[eth.eth_month];
                greg.greg_year  = year_high;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/ethiopian_to_gregorian_date.sv
// Converts an Ethiopian date item into a Gregorian date item. The block is a two-stage
// pipeline. An input register holds the accepted date. The conversion logic (table
// lookups, one constant multiply for the century leap test, a compare and an add)
// sits between that register and the result register. One item is accepted every
// cycle while the output is not stalled. Each result goes from the input register
// through the result register to greg_date. A stalled output fills both
// registers before eth_ready drops. Months above Pagume give an all-zero result with
// valid_res low. There is no configuration and reset only clears the valid flags.
`default_nettype none

module ethiopian_to_gregorian_date (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      eth_valid,
    output logic                     eth_ready,
    input  wire e2g_pkg::eth_date_t  eth_date,
    output logic                     greg_valid,
    input  wire                      greg_ready,
    output e2g_pkg::greg_date_t      greg_date
);
    import e2g_pkg::*;

    logic       in_valid_reg;
    eth_date_t  in_date_reg;
    logic       greg_valid_reg;
    greg_date_t greg_date_reg;
    greg_date_t greg_date_next;
    logic       out_advance;
    logic       in_advance;

    // Each stage moves on when the stage after it is empty or being emptied.
    assign out_advance = !greg_valid_reg || greg_ready;
    assign in_advance  = !in_valid_reg || out_advance;
    assign eth_ready   = in_advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_advance)
        begin
            in_valid_reg <= eth_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_advance && eth_valid)
        begin
            in_date_reg <= eth_date;
        end
    end

    // Conversion logic.
    e2g_convert u_convert (
        .eth  (in_date_reg),
        .greg (greg_date_next)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            greg_valid_reg <= 1'b0;
        end
        else if (out_advance)
        begin
            greg_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_advance && in_valid_reg)
        begin
            greg_date_reg <= greg_date_next;
        end
    end

    assign greg_valid = greg_valid_reg;
    assign greg_date  = greg_date_reg;

endmodule

`default_nettype wire

// File: rtl/e2g_checker.sv
`default_nettype none
`include "ethiopian_to_gregorian_date_macros.svh"

module e2g_checker (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      eth_valid,
    input  wire                      eth_ready,
    input  wire e2g_pkg::eth_date_t  eth_date,
    input  wire                      greg_valid,
    input  wire                      greg_ready,
    input  wire e2g_pkg::greg_date_t greg_date
);
    import e2g_pkg::*;

    logic eth_seen;

    // The input item itself only matters for the valid flag check below.
    assign eth_seen = eth_valid && eth_ready && (eth_date.eth_month <= MONTH_PAGUME);

    // A result held back by the sink stays put.
    `E2G_ASSERT_NEXT(a_out_hold, greg_valid && !greg_ready, greg_valid && $stable(greg_date))

    // With the output empty the pipeline always has room for a new item.
    `E2G_ASSERT_SAME(a_ready_when_empty, !greg_valid, eth_ready)

    // A valid conversion always names a real Gregorian month.
    `E2G_ASSERT_SAME(a_month_range, greg_valid && greg_date.valid_res,
        (greg_date.greg_month >= 4'd1) && (greg_date.greg_month <= 4'd12))

    // An invalid month gives an all-zero result.
    `E2G_ASSERT_SAME(a_invalid_zero, greg_valid && !greg_date.valid_res,
        (greg_date.greg_day == '0) && (greg_date.greg_month == '0)
        && (greg_date.greg_year == '0))

    // An accepted valid month with both registers empty is shown valid once it has passed
    // through the input and result registers. An empty output with no item taken at the
    // edge before means the input register is empty too.
    `E2G_ASSERT_NEXT(a_valid_flag, eth_seen && !greg_valid && !$past(eth_valid && eth_ready),
        ##1 (greg_valid && greg_date.valid_res))

endmodule

bind ethiopian_to_gregorian_date e2g_checker u_e2g_checker (.*);

`default_nettype wire
